>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the keyboard character queue.
// Depends on nothing; both macros need clock in scope, HRA_ASSERT also reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HRA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/hra_pkg.sv
// Package of the keyboard report to ASCII queue: sequencer states, constants
// and the US layout key usage table. Depends on nothing.
package hra_pkg;

   localparam int CHAR_W     = 7;
   localparam int USAGE_W    = 8;
   localparam int MAX_SLOTS  = 6;
   localparam int TABLE_SIZE = 92;
   localparam int FILL_W     = 8;
   localparam int DROP_W     = 3;
   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [CHAR_W-1:0] ASCII_ESC = 7'd27;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } seq_state_type;

   // US layout: usage code to ASCII, plain or shifted. Unmapped codes give 0.
   function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [USAGE_W-1:0] usage,
                                                     input logic shifted);
      logic [USAGE_W-1:0] letter;
      logic [CHAR_W-1:0]  res;
      begin
         letter = usage + (shifted ? 8'h3D : 8'h5D);
         res    = '0;
         if (usage >= 8'd4 && usage <= 8'd29) begin
            res = letter[CHAR_W-1:0];
         end else begin
            case (usage)
               8'd30:   res = shifted ? 7'h21 : 7'h31;
               8'd31:   res = shifted ? 7'h40 : 7'h32;
               8'd32:   res = shifted ? 7'h23 : 7'h33;
               8'd33:   res = shifted ? 7'h24 : 7'h34;
               8'd34:   res = shifted ? 7'h25 : 7'h35;
               8'd35:   res = shifted ? 7'h5E : 7'h36;
               8'd36:   res = shifted ? 7'h26 : 7'h37;
               8'd37:   res = shifted ? 7'h2A : 7'h38;
               8'd38:   res = shifted ? 7'h28 : 7'h39;
               8'd39:   res = shifted ? 7'h29 : 7'h30;
               8'd40:   res = 7'h0A;
               8'd41:   res = ASCII_ESC;
               8'd42:   res = 7'h08;
               8'd43:   res = 7'h09;
               8'd44:   res = 7'h20;
               8'd45:   res = shifted ? 7'h5F : 7'h2D;
               8'd46:   res = shifted ? 7'h2B : 7'h3D;
               8'd47:   res = shifted ? 7'h7B : 7'h5B;
               8'd48:   res = shifted ? 7'h7D : 7'h5D;
               8'd49:   res = shifted ? 7'h7C : 7'h5C;
               8'd51:   res = shifted ? 7'h3A : 7'h3B;
               8'd52:   res = shifted ? 7'h22 : 7'h27;
               8'd53:   res = shifted ? 7'h7E : 7'h60;
               8'd54:   res = shifted ? 7'h3C : 7'h2C;
               8'd55:   res = shifted ? 7'h3E : 7'h2E;
               8'd56:   res = shifted ? 7'h3F : 7'h2F;
               default: res = '0;
            endcase
         end
         return res;
      end
   endfunction

endpackage

>>> rtl/hid_report_to_ascii_fifo_unit.sv
// Keyboard report to ASCII queue, top level.
// A report runs in ST_WRITE, a read in ST_READ; then ST_DONE waits for a free output register;
// the next item is taken in the cycle after the result is registered, while it may still wait.
// The pace of a report is set by the single write port of the store: one slot per cycle.
// Reset is synchronous and active high; it empties the queue and clears all control state.
// Depends on hra_pkg, hra_lane, hra_ring and assert_macros.svh.
module hid_report_to_ascii_fifo_unit #(
   parameter int BUFFER_DEPTH = 256,
   parameter int KEY_SLOTS    = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [7:0]                  req_modifiers,
   input  logic [7:0]                  req_key_slot_0,
   input  logic [7:0]                  req_key_slot_1,
   input  logic [7:0]                  req_key_slot_2,
   input  logic [7:0]                  req_key_slot_3,
   input  logic [7:0]                  req_key_slot_4,
   input  logic [7:0]                  req_key_slot_5,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hra_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic                        rsp_char_valid,
   output logic [hra_pkg::FILL_W-1:0]  rsp_fill_level,
   output logic                        rsp_has_input,
   output logic [hra_pkg::DROP_W-1:0]  rsp_dropped
);

   `include "assert_macros.svh"

   // Pointer and count width; the count never exceeds BUFFER_DEPTH - 1.
   localparam int AW = $clog2(BUFFER_DEPTH);
   // Slot counter width, kept at one bit for a single slot.
   localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);
   localparam logic [AW-1:0] FULL_COUNT = AW'(BUFFER_DEPTH - 1);

   // ------------------------------------------------------------------
   // Lanes: every key slot is translated at once when a report arrives.
   // ------------------------------------------------------------------
   logic [hra_pkg::USAGE_W-1:0] slot_all [hra_pkg::MAX_SLOTS];
   logic [hra_pkg::CHAR_W-1:0]  lane_char [KEY_SLOTS];
   logic                        shifted;

   assign slot_all[0] = req_key_slot_0;
   assign slot_all[1] = req_key_slot_1;
   assign slot_all[2] = req_key_slot_2;
   assign slot_all[3] = req_key_slot_3;
   assign slot_all[4] = req_key_slot_4;
   assign slot_all[5] = req_key_slot_5;

   assign shifted = (req_modifiers & hra_pkg::SHIFT_MASK) != 8'h00;

   for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
      hra_lane u_lane (
         .usage     (slot_all[g]),
         .shifted   (shifted),
         .char_code (lane_char[g])
      );
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   hra_pkg::seq_state_type state_ff, state_in;
   logic [SW-1:0]               slot_cnt_ff, slot_cnt_in;
   logic [hra_pkg::CHAR_W-1:0]  chars_ff [KEY_SLOTS];
   logic [hra_pkg::CHAR_W-1:0]  chars_in [KEY_SLOTS];
   logic [AW-1:0]               rp_ff, rp_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [AW-1:0]               count_ff, count_in;
   logic [hra_pkg::DROP_W-1:0]  lost_ff, lost_in;
   logic [hra_pkg::CHAR_W-1:0]  res_char_ff, res_char_in;
   logic                        res_valid_ff, res_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hra_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                        rsp_cvalid_ff, rsp_cvalid_in;
   logic [hra_pkg::FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic                        rsp_has_ff, rsp_has_in;
   logic [hra_pkg::DROP_W-1:0]  rsp_drop_ff, rsp_drop_in;

   // Store interface.
   logic                        wr_en;
   logic [hra_pkg::CHAR_W-1:0]  rd_data;
   logic                        req_fire;
   logic                        out_free;

   assign req_ready = (state_ff == hra_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   // The output register can take a new result when empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // A slot character is stored unless it is empty or the queue is full.
   assign wr_en = (state_ff == hra_pkg::ST_WRITE) && (chars_ff[0] != '0) &&
                  (count_ff != FULL_COUNT);

   hra_ring #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (chars_ff[0]),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // Sequencer. A report walks its translated slots in order, one per
   // cycle, by shifting the lane results down towards slot zero. A read
   // uses the store word that was read at the read pointer on the
   // acceptance edge; no write can land in the queue at that edge.
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      slot_cnt_in  = slot_cnt_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      lost_in      = lost_ff;
      res_char_in  = res_char_ff;
      res_valid_in = res_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_drop_in  = rsp_drop_ff;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         chars_in[i] = chars_ff[i];
      end

      case (state_ff)
         hra_pkg::ST_IDLE: begin
            if (req_fire) begin
               lost_in      = '0;
               res_char_in  = '0;
               res_valid_in = 1'b0;
               slot_cnt_in  = SW'(KEY_SLOTS - 1);
               if (req_operation) begin
                  state_in = hra_pkg::ST_READ;
               end else begin
                  state_in = hra_pkg::ST_WRITE;
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     chars_in[i] = lane_char[i];
                  end
               end
            end
         end

         hra_pkg::ST_WRITE: begin
            if (chars_ff[0] != '0) begin
               if (count_ff != FULL_COUNT) begin
                  wp_in    = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  lost_in = lost_ff + 1'b1;
               end
            end
            for (int i = 0; i < KEY_SLOTS - 1; i++) begin
               chars_in[i] = chars_ff[i + 1];
            end
            chars_in[KEY_SLOTS - 1] = '0;
            slot_cnt_in = slot_cnt_ff - 1'b1;
            if (slot_cnt_ff == '0) begin
               state_in = hra_pkg::ST_DONE;
            end
         end

         hra_pkg::ST_READ: begin
            if (count_ff != '0) begin
               res_char_in  = rd_data;
               res_valid_in = 1'b1;
               rp_in        = (rp_ff == LAST_ADDR) ? '0 : rp_ff + 1'b1;
               count_in     = count_ff - 1'b1;
            end
            state_in = hra_pkg::ST_DONE;
         end

         hra_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = res_char_ff;
               rsp_cvalid_in = res_valid_ff;
               rsp_fill_in   = hra_pkg::FILL_W'(count_ff);
               rsp_has_in    = (count_ff != '0);
               rsp_drop_in   = lost_ff;
               state_in      = hra_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hra_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hra_pkg::ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_cnt_ff   <= slot_cnt_in;
      lost_ff       <= lost_in;
      res_char_ff   <= res_char_in;
      res_valid_ff  <= res_valid_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_drop_ff   <= rsp_drop_in;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         chars_ff[i] <= chars_in[i];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_out   = rsp_char_ff;
   assign rsp_char_valid = rsp_cvalid_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_has_input  = rsp_has_ff;
   assign rsp_dropped    = rsp_drop_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // An accepted item always leaves the sequencer busy in the following cycle.
   `HRA_ASSERT(a_busy_after_accept, req_fire |=> (state_ff != hra_pkg::ST_IDLE), "item accepted but sequencer idle")
   // A full queue stays full while a report is being written.
   `HRA_ASSERT(a_full_holds, (state_ff == hra_pkg::ST_WRITE) && (count_ff == FULL_COUNT) |=> (count_ff == FULL_COUNT), "full queue changed during a report")
   // A read of a non-empty queue removes exactly one character.
   `HRA_ASSERT(a_pop_one, (state_ff == hra_pkg::ST_READ) && (count_ff != '0) |=> (count_ff == AW'($past(count_ff) - 1'b1)), "read did not remove one character")
   // After reset the sequencer is idle and no result is offered.
   `HRA_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == hra_pkg::ST_IDLE) && !rsp_valid_ff, "sequencer not idle after reset")

endmodule

>>> rtl/hra_lane.sv
// One key slot lane: range check of the usage code and layout lookup.
// Depends on hra_pkg.
module hra_lane (
   input  logic [hra_pkg::USAGE_W-1:0] usage,
   input  logic                        shifted,
   output logic [hra_pkg::CHAR_W-1:0]  char_code
);

   logic in_range;

   // Empty slots and codes beyond the table give no character.
   assign in_range  = (usage != '0) && (usage < 8'(hra_pkg::TABLE_SIZE));
   assign char_code = in_range ? hra_pkg::key_to_ascii(usage, shifted) : '0;

endmodule

>>> rtl/hra_ring.sv
// Character store of the queue: one write port, one registered read port.
// Depends on hra_pkg.
module hra_ring #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [hra_pkg::CHAR_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [hra_pkg::CHAR_W-1:0] rd_data
);

   logic [hra_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [hra_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/kbq_test_pkg.sv
// Shared definitions for the keyboard character queue testbench: item operation codes
// and the packed row of six key usages. Depends on nothing.
package kbq_test_pkg;

   typedef enum logic {
      OP_REPORT = 1'b0,
      OP_READ   = 1'b1
   } queue_op_e;

   // Slot 0 is the leftmost element, so a concatenation lists the slots in order.
   typedef logic [0:5][7:0] key_row_t;

endpackage

>>> test/kbq_checker.sv
// Checker for the keyboard character queue: watches both channels, predicts each result
// from its own copy of the character ring, and compares. Depends on kbq_test_pkg and hra_pkg.
module kbq_checker
   import kbq_test_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int SLOTS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_operation,
   input  logic [7:0]                  req_modifiers,
   input  logic [7:0]                  req_key_slot_0,
   input  logic [7:0]                  req_key_slot_1,
   input  logic [7:0]                  req_key_slot_2,
   input  logic [7:0]                  req_key_slot_3,
   input  logic [7:0]                  req_key_slot_4,
   input  logic [7:0]                  req_key_slot_5,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [hra_pkg::CHAR_W-1:0]  rsp_char_out,
   input  logic                        rsp_char_valid,
   input  logic [hra_pkg::FILL_W-1:0]  rsp_fill_level,
   input  logic                        rsp_has_input,
   input  logic [hra_pkg::DROP_W-1:0]  rsp_dropped,
   output int                          fail_count,
   output int                          pending,
   output int                          empty_reads,
   output int                          overflow_reports,
   output int                          peak_fill
);

   localparam logic [7:0] SHIFT_BITS = 8'h22;

   typedef struct {
      logic [6:0] ch;
      logic       ch_ok;
      logic [7:0] fill;
      logic       nonempty;
      logic [2:0] lost;
   } queue_result_t;

   queue_result_t awaited_results [$];
   logic [6:0]    queued_chars [DEPTH];
   int            rd_pos;
   int            wr_pos;
   int            held;

   // US layout translation of one usage code; zero where the key has no character.
   function automatic logic [6:0] usage_char(input logic [7:0] usage, input bit shifted);
      string digits;
      string marks;
      if (shifted) begin
         digits = "!@#$%^&*()";
         marks  = "_+{}|#:\"~<>?";
      end else begin
         digits = "1234567890";
         marks  = "-=[]\\#;'`,./";
      end
      if (usage >= 8'd4 && usage <= 8'd29)
         return 7'(usage - 8'd4 + (shifted ? "A" : "a"));
      if (usage >= 8'd30 && usage <= 8'd39)
         return 7'(digits[usage - 30]);
      case (usage)
         8'd40: return 7'd10;
         8'd41: return 7'd27;
         8'd42: return 7'd8;
         8'd43: return 7'd9;
         8'd44: return 7'(" ");
         8'd50: return 7'd0;
         default: ;
      endcase
      if (usage >= 8'd45 && usage <= 8'd56)
         return 7'(marks[usage - 45]);
      return 7'd0;
   endfunction

   function automatic void advance_queue_model();
      queue_result_t res;
      key_row_t      keys;
      logic [6:0]    c;
      bit            shifted;
      int            lost;
      res   = '{default: '0};
      lost  = 0;
      keys  = {req_key_slot_0, req_key_slot_1, req_key_slot_2,
               req_key_slot_3, req_key_slot_4, req_key_slot_5};
      if (req_operation == OP_REPORT) begin
         shifted = (req_modifiers & SHIFT_BITS) != 0;
         for (int i = 0; i < SLOTS; i++) begin
            c = usage_char(keys[i], shifted);
            if (c != 0) begin
               if (held < DEPTH - 1) begin
                  queued_chars[wr_pos] = c;
                  wr_pos = (wr_pos + 1) % DEPTH;
                  held++;
               end else begin
                  lost++;
               end
            end
         end
         if (lost != 0)
            overflow_reports++;
      end else if (held != 0) begin
         res.ch    = queued_chars[rd_pos];
         res.ch_ok = 1'b1;
         rd_pos    = (rd_pos + 1) % DEPTH;
         held--;
      end else begin
         empty_reads++;
      end
      res.fill     = held[7:0];
      res.nonempty = held != 0;
      res.lost     = lost[2:0];
      if (held > peak_fill)
         peak_fill = held;
      awaited_results.push_back(res);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void compare_result();
      queue_result_t want;
      if (awaited_results.size() == 0) begin
         $error("Result with nothing outstanding: char_out %0d, fill_level %0d",
                rsp_char_out, rsp_fill_level);
         fail_count++;
      end else begin
         want = awaited_results.pop_front();
         check_field("char_out", want.ch, rsp_char_out);
         check_field("char_valid", want.ch_ok, rsp_char_valid);
         check_field("fill_level", want.fill, rsp_fill_level);
         check_field("has_input", want.nonempty, rsp_has_input);
         check_field("dropped", want.lost, rsp_dropped);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         awaited_results.delete();
         rd_pos           = 0;
         wr_pos           = 0;
         held             = 0;
         fail_count       = 0;
         pending          = 0;
         empty_reads      = 0;
         overflow_reports = 0;
         peak_fill        = 0;
      end else begin
         // Results leave before this edge's item is predicted, so a stray result
         // can never be matched against an expectation made in the same cycle.
         if (rsp_valid && rsp_ready)
            compare_result();
         if (req_valid && req_ready)
            advance_queue_model();
         pending = awaited_results.size();
      end
   end

endmodule

>>> test/tb_top.sv
// Top of the keyboard character queue testbench: clock, reset, stimulus and verdict.
// Depends on kbq_test_pkg, kbq_checker and the hid_report_to_ascii_fifo_unit RTL.
module tb_top;
   import kbq_test_pkg::*;

   // Stimulus stops once this many items have been accepted.
   localparam int TOTAL_ITEMS = 1150;
   // Items per idling phase in the random part.
   localparam int PHASE_ITEMS = 290;
   // The settle time allows for a report to pass through the block, and more.
   localparam int SETTLE_CYCLES = 20;
   // Far above the slowest correct run.
   localparam int CYCLE_LIMIT = 300000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = OP_REPORT;
   logic [7:0] req_modifiers = 8'h00;
   logic [7:0] req_key_slot_0 = 8'h00;
   logic [7:0] req_key_slot_1 = 8'h00;
   logic [7:0] req_key_slot_2 = 8'h00;
   logic [7:0] req_key_slot_3 = 8'h00;
   logic [7:0] req_key_slot_4 = 8'h00;
   logic [7:0] req_key_slot_5 = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [hra_pkg::CHAR_W-1:0] rsp_char_out;
   logic                       rsp_char_valid;
   logic [hra_pkg::FILL_W-1:0] rsp_fill_level;
   logic                       rsp_has_input;
   logic [hra_pkg::DROP_W-1:0] rsp_dropped;

   int fail_count;
   int pending;
   int empty_reads;
   int overflow_reports;
   int peak_fill;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int reads_sent = 0;
   int cycle_count = 0;

   hid_report_to_ascii_fifo_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_modifiers  (req_modifiers),
      .req_key_slot_0 (req_key_slot_0),
      .req_key_slot_1 (req_key_slot_1),
      .req_key_slot_2 (req_key_slot_2),
      .req_key_slot_3 (req_key_slot_3),
      .req_key_slot_4 (req_key_slot_4),
      .req_key_slot_5 (req_key_slot_5),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_out   (rsp_char_out),
      .rsp_char_valid (rsp_char_valid),
      .rsp_fill_level (rsp_fill_level),
      .rsp_has_input  (rsp_has_input),
      .rsp_dropped    (rsp_dropped)
   );

   kbq_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_modifiers    (req_modifiers),
      .req_key_slot_0   (req_key_slot_0),
      .req_key_slot_1   (req_key_slot_1),
      .req_key_slot_2   (req_key_slot_2),
      .req_key_slot_3   (req_key_slot_3),
      .req_key_slot_4   (req_key_slot_4),
      .req_key_slot_5   (req_key_slot_5),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_has_input    (rsp_has_input),
      .rsp_dropped      (rsp_dropped),
      .fail_count       (fail_count),
      .pending          (pending),
      .empty_reads      (empty_reads),
      .overflow_reports (overflow_reports),
      .peak_fill        (peak_fill)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver decides afresh at every edge whether it will take a result.
   initial begin
      forever begin
         @(posedge clock);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Usage codes weighted towards keys that produce characters, with a share of empty
   // slots, keys with no character and codes beyond the table.
   function automatic logic [7:0] pick_usage();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return 8'($urandom_range(56, 4));
      if (roll < 80)
         return 8'd0;
      if (roll < 90)
         return 8'($urandom_range(91, 57));
      return 8'($urandom_range(255, 92));
   endfunction

   function automatic key_row_t pressed_keys(input bit noisy);
      key_row_t keys;
      for (int i = 0; i < 6; i++)
         keys[i] = noisy ? 8'($urandom_range(255)) : pick_usage();
      return keys;
   endfunction

   // Called on a rising edge; returns on the rising edge at which the item was accepted.
   // The ready line is looked at on the falling edge, where it is settled, and is then
   // held until the next rising edge because the block only changes it on that edge.
   task automatic send_item(input queue_op_e op, input logic [7:0] mods,
                            input key_row_t keys);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_modifiers  <= mods;
      req_key_slot_0 <= keys[0];
      req_key_slot_1 <= keys[1];
      req_key_slot_2 <= keys[2];
      req_key_slot_3 <= keys[3];
      req_key_slot_4 <= keys[4];
      req_key_slot_5 <= keys[5];
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
      if (op == OP_READ)
         reads_sent++;
   endtask

   // Withdraws valid and waits until every outstanding result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      int phase;
      int last_phase;
      int kind;
      int burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: a read of the empty queue (its unused fields all ones), an empty
      // report, both ends of the letter and digit ranges, the control keys, the
      // punctuation keys 51 to 56 plain and shifted, each shift bit alone and both together,
      // modifier bytes without shift, the unmapped key inside the punctuation block,
      // keys past the punctuation block, codes at and beyond the end of the table,
      // and then reads that give back what was queued.
      send_item(OP_READ, 8'hFF, {6{8'hFF}});
      send_item(OP_REPORT, 8'h00, {6{8'h00}});
      send_item(OP_REPORT, 8'h00, {8'd4, 8'd29, 8'd30, 8'd39, 8'd40, 8'd41});
      send_item(OP_REPORT, 8'h02, {8'd4, 8'd29, 8'd30, 8'd39, 8'd40, 8'd41});
      send_item(OP_REPORT, 8'h20, {8'd42, 8'd43, 8'd44, 8'd45, 8'd49, 8'd50});
      send_item(OP_REPORT, 8'hDD, {8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56});
      send_item(OP_REPORT, 8'hFF, {8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56});
      send_item(OP_REPORT, 8'h22, {8'd57, 8'd91, 8'd92, 8'd255, 8'd1, 8'd3});
      send_item(OP_REPORT, 8'h00, {8'd0, 8'd2, 8'd128, 8'd200, 8'd0, 8'd56});
      repeat (12) send_item(OP_READ, 8'($urandom_range(255)), pressed_keys(1'b1));

      // Random part, in bursts. Filling bursts of reports drive the queue to its limit
      // so that characters are dropped and the pointers wrap; long runs of reads drain
      // it past empty. Mixed bursts and bursts of arbitrary bytes fill the gaps.
      last_phase = -1;
      while (items_sent < TOTAL_ITEMS) begin
         phase = items_sent / PHASE_ITEMS;
         if (phase > 3)
            phase = 3;
         if (phase != last_phase) begin
            // The sender waits for every outstanding result before each change of pace.
            wait_drained();
            case (phase)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 67; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 67; end
               default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            last_phase = phase;
         end
         kind = $urandom_range(7);
         case (kind)
            0, 1, 2: begin
               burst = $urandom_range(70, 10);
               for (int k = 0; k < burst && items_sent < TOTAL_ITEMS; k++)
                  send_item(OP_REPORT, 8'($urandom_range(255)), pressed_keys(1'b0));
            end
            3, 4: begin
               burst = $urandom_range(300, 5);
               for (int k = 0; k < burst && items_sent < TOTAL_ITEMS; k++)
                  send_item(OP_READ, 8'($urandom_range(255)), pressed_keys(1'b1));
            end
            5: begin
               burst = $urandom_range(80, 20);
               for (int k = 0; k < burst && items_sent < TOTAL_ITEMS; k++) begin
                  if ($urandom_range(1) == 0)
                     send_item(OP_REPORT, 8'($urandom_range(255)), pressed_keys(1'b0));
                  else
                     send_item(OP_READ, 8'($urandom_range(255)), pressed_keys(1'b0));
               end
            end
            default: begin
               burst = $urandom_range(10, 3);
               for (int k = 0; k < burst && items_sent < TOTAL_ITEMS; k++)
                  send_item(queue_op_e'($urandom_range(1)), 8'($urandom_range(255)),
                            pressed_keys(1'b1));
            end
         endcase
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items, %0d of them reads (%0d on an empty queue).",
               items_sent, reads_sent, empty_reads);
      $display("Queue peaked at %0d characters; %0d reports lost characters to a full queue.",
               peak_fill, overflow_reports);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
